[sv/implicit_surface_normal_top_assert.svh]
// Assertion macros for the implicit surface normal block
`ifndef IMPLICIT_SURFACE_NORMAL_TOP_ASSERT_SVH
`define IMPLICIT_SURFACE_NORMAL_TOP_ASSERT_SVH

// same-cycle implication
`define ISN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ISN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/isn_pkg.sv]
`default_nettype none
package isn_pkg;

    localparam int unsigned DIM = 3;

    typedef enum logic [1:0] {
        KIND_PLANE   = 2'd0,
        KIND_QUADRIC = 2'd1,
        KIND_TORUS   = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_DEGEN   = 2'd2,
        STAT_SAT     = 2'd3
    } status_t;

    typedef enum logic [17:0] {
        ST_IDLE   = 18'h00001,
        ST_PLANE  = 18'h00002,
        ST_QINIT  = 18'h00004,
        ST_QMUL   = 18'h00008,
        ST_QACC   = 18'h00010,
        ST_TD     = 18'h00020,
        ST_TPMUL  = 18'h00040,
        ST_TPACC  = 18'h00080,
        ST_TLMUL  = 18'h00100,
        ST_TLACC  = 18'h00200,
        ST_NSQ    = 18'h00400,
        ST_NSACC  = 18'h00800,
        ST_SQRT   = 18'h01000,
        ST_DIVSET = 18'h02000,
        ST_DIV    = 18'h04000,
        ST_RMUL   = 18'h08000,
        ST_RACC   = 18'h10000,
        ST_FIN    = 18'h20000
    } state_t;

    // {saturated, value}
    function automatic logic [32:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (x < -64'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, x[31:0]};
        end
    endfunction

endpackage
`default_nettype wire

[sv/implicit_surface_normal_top.sv]
// Channel | Direction | Signals
// s_      | in        | s_valid/s_ready, s_func, s_coef_index, s_coef_value, s_point_x/y/z
// m_      | out       | m_valid/m_ready, m_normal_x/y/z, m_status
// cfg_    | in        | cfg_valid/cfg_ready, cfg_data (surface kind)
//
// One transaction at a time; s_ready is high only while the sequencer is idle.
// Quadric: 3x3 multiplies on one shared multiplier. Torus: paced by the 1-bit/cycle square root
// and restoring divider. A stalled result holds in the output register until taken.
// Synchronous active-low reset clears control state only; the coefficient table is not reset.
`default_nettype none
module implicit_surface_normal_top
    import isn_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [3:0]         s_coef_index,
    input  wire logic signed [31:0] s_coef_value,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_y,
    input  wire logic signed [31:0] s_point_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_normal_x,
    output logic signed [31:0]      m_normal_y,
    output logic signed [31:0]      m_normal_z,
    output logic [1:0]              m_status
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW);

    state_t state_reg, state_next;
    kind_t  kind_reg;

    logic signed [31:0] tbl_reg [16];
    logic signed [31:0] p_reg [DIM];
    logic signed [31:0] d_reg [DIM];
    logic signed [31:0] v_reg [DIM];
    logic signed [31:0] w_reg [DIM];
    logic signed [31:0] n_reg [DIM];
    logic signed [31:0] tp_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [1:0]         i_reg, j_reg;
    logic [CW-1:0]      cnt_reg;
    logic               pass_reg, sat_reg, deg_reg, inv_reg, neg_reg;
    logic [35:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [31:0]        dr_reg;
    logic [NW-1:0]      dq_reg;
    logic               m_valid_reg;
    logic signed [31:0] mo_reg [DIM];
    logic [1:0]         ms_reg;

    logic [3:0]         rd_idx;
    logic signed [31:0] tbl_rd;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] qsh;
    logic signed [63:0] sum;
    logic [32:0]        sat_sum, sat_dp, sat_dq, sat_tp;
    logic [35:0]        rem_sh, trial;
    logic [35:0]        rem_next;
    logic [31:0]        root_next;
    logic [32:0]        dr_sh;
    logic [31:0]        dr_next;
    logic [NW-1:0]      dq_next;
    logic [32:0]        vmag;
    logic [31:0]        qres;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_normal_x = mo_reg[0];
    assign m_normal_y = mo_reg[1];
    assign m_normal_z = mo_reg[2];
    assign m_status   = ms_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        unique case (state_reg)
            ST_QINIT:          rd_idx = 4'd12 + {2'b00, i_reg};
            ST_QMUL:           rd_idx = {j_reg, i_reg};
            ST_TPMUL, ST_TLMUL: rd_idx = 4'd3 + {2'b00, i_reg};
            ST_RMUL:           rd_idx = 4'd6;
            default:           rd_idx = {2'b00, i_reg};
        endcase
    end
    assign tbl_rd = tbl_reg[rd_idx];

    always_comb begin
        unique case (state_reg)
            ST_QMUL: begin
                mul_a = tbl_rd;
                mul_b = p_reg[j_reg];
            end
            ST_TPMUL: begin
                mul_a = d_reg[i_reg];
                mul_b = tbl_rd;
            end
            ST_TLMUL: begin
                mul_a = tp_reg;
                mul_b = tbl_rd;
            end
            ST_RMUL: begin
                mul_a = tbl_rd;
                mul_b = w_reg[i_reg];
            end
            default: begin
                mul_a = v_reg[i_reg];
                mul_b = v_reg[i_reg];
            end
        endcase
    end

    assign qsh     = prod_reg >>> FRAC_BITS;
    assign sum     = acc_reg + qsh;
    assign sat_sum = sat32(sum);
    assign sat_dq  = sat32(64'(d_reg[i_reg]) - qsh);
    assign sat_dp  = sat32(64'(p_reg[i_reg]) - 64'(tbl_rd));
    assign sat_tp  = sat_sum;

    // square root step
    assign rem_sh = {rem_reg[33:0], acc_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    always_comb begin
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[30:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_reg[30:0], 1'b0};
        end
    end

    // divider step
    assign dr_sh = {dr_reg, dq_reg[NW-1]};
    always_comb begin
        if (dr_sh >= {1'b0, root_reg}) begin
            dr_next = 32'(dr_sh - {1'b0, root_reg});
            dq_next = {dq_reg[NW-2:0], 1'b1};
        end else begin
            dr_next = dr_sh[31:0];
            dq_next = {dq_reg[NW-2:0], 1'b0};
        end
    end
    assign qres = neg_reg ? 32'(-dq_next[31:0]) : dq_next[31:0];
    assign vmag = v_reg[i_reg][31] ? 33'(-{1'b1, v_reg[i_reg]}) : {1'b0, v_reg[i_reg]};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_func) begin
                        state_next = ST_FIN;
                    end else begin
                        unique case (kind_reg)
                            KIND_PLANE:   state_next = ST_PLANE;
                            KIND_QUADRIC: state_next = ST_QINIT;
                            KIND_TORUS:   state_next = ST_TD;
                            default:      state_next = ST_FIN;
                        endcase
                    end
                end
            end
            ST_PLANE:  state_next = (i_reg == 2'd2) ? ST_FIN : ST_PLANE;
            ST_QINIT:  state_next = ST_QMUL;
            ST_QMUL:   state_next = ST_QACC;
            ST_QACC: begin
                if (j_reg != 2'd2) begin
                    state_next = ST_QMUL;
                end else begin
                    state_next = (i_reg == 2'd2) ? ST_FIN : ST_QINIT;
                end
            end
            ST_TD:     state_next = (i_reg == 2'd2) ? ST_TPMUL : ST_TD;
            ST_TPMUL:  state_next = ST_TPACC;
            ST_TPACC:  state_next = (i_reg == 2'd2) ? ST_TLMUL : ST_TPMUL;
            ST_TLMUL:  state_next = ST_TLACC;
            ST_TLACC:  state_next = (i_reg == 2'd2) ? ST_NSQ : ST_TLMUL;
            ST_NSQ:    state_next = ST_NSACC;
            ST_NSACC:  state_next = (i_reg == 2'd2) ? ST_SQRT : ST_NSQ;
            ST_SQRT: begin
                if (cnt_reg == CW'(31)) begin
                    state_next = (root_next == 32'd0) ? ST_FIN : ST_DIVSET;
                end
            end
            ST_DIVSET: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CW'(NW - 1)) begin
                    if (i_reg != 2'd2) begin
                        state_next = ST_DIVSET;
                    end else begin
                        state_next = pass_reg ? ST_FIN : ST_RMUL;
                    end
                end
            end
            ST_RMUL:   state_next = ST_RACC;
            ST_RACC:   state_next = (i_reg == 2'd2) ? ST_NSQ : ST_RMUL;
            ST_FIN:    state_next = out_free ? ST_IDLE : ST_FIN;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= KIND_PLANE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                kind_reg <= kind_t'(cfg_data);
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    p_reg[0] <= s_point_x;
                    p_reg[1] <= s_point_y;
                    p_reg[2] <= s_point_z;
                    for (int k = 0; k < DIM; k++) begin
                        n_reg[k] <= '0;
                    end
                    i_reg    <= '0;
                    j_reg    <= '0;
                    acc_reg  <= '0;
                    pass_reg <= 1'b0;
                    sat_reg  <= 1'b0;
                    deg_reg  <= 1'b0;
                    inv_reg  <= s_func && (kind_reg == KIND_INVALID);
                    if (!s_func) begin
                        tbl_reg[s_coef_index] <= s_coef_value;
                    end
                end
            end
            ST_PLANE: begin
                n_reg[i_reg] <= tbl_rd;
                i_reg <= i_reg + 2'd1;
            end
            ST_QINIT: begin
                acc_reg <= 64'(tbl_rd);
                j_reg   <= '0;
            end
            ST_QACC: begin
                acc_reg <= sum;
                if (j_reg != 2'd2) begin
                    j_reg <= j_reg + 2'd1;
                end else begin
                    n_reg[i_reg] <= sat_sum[31:0];
                    sat_reg      <= sat_reg | sat_sum[32];
                    i_reg        <= i_reg + 2'd1;
                end
            end
            ST_TD: begin
                d_reg[i_reg] <= sat_dp[31:0];
                sat_reg      <= sat_reg | sat_dp[32];
                i_reg        <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                acc_reg      <= '0;
            end
            ST_TPACC: begin
                acc_reg <= sum;
                if (i_reg == 2'd2) begin
                    tp_reg  <= sat_tp[31:0];
                    sat_reg <= sat_reg | sat_tp[32];
                    i_reg   <= '0;
                end else begin
                    i_reg <= i_reg + 2'd1;
                end
            end
            ST_TLACC, ST_RACC: begin
                v_reg[i_reg] <= sat_dq[31:0];
                sat_reg      <= sat_reg | sat_dq[32];
                acc_reg      <= '0;
                if (i_reg == 2'd2) begin
                    i_reg <= '0;
                    if (state_reg == ST_RACC) begin
                        pass_reg <= 1'b1;
                    end
                end else begin
                    i_reg <= i_reg + 2'd1;
                end
            end
            ST_NSACC: begin
                acc_reg <= acc_reg + prod_reg;
                i_reg   <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                cnt_reg <= '0;
                rem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT: begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                acc_reg  <= acc_reg <<< 2;
                cnt_reg  <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(31) && root_next == 32'd0) begin
                    deg_reg <= 1'b1;
                    for (int k = 0; k < DIM; k++) begin
                        n_reg[k] <= '0;
                    end
                end
            end
            ST_DIVSET: begin
                dq_reg  <= NW'(vmag[31:0]) << FRAC_BITS;
                dr_reg  <= '0;
                neg_reg <= v_reg[i_reg][31];
                cnt_reg <= '0;
            end
            ST_DIV: begin
                dr_reg  <= dr_next;
                dq_reg  <= dq_next;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1)) begin
                    if (pass_reg) begin
                        n_reg[i_reg] <= qres;
                    end else begin
                        w_reg[i_reg] <= qres;
                    end
                    i_reg <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    for (int k = 0; k < DIM; k++) begin
                        mo_reg[k] <= n_reg[k];
                    end
                    if (deg_reg) begin
                        ms_reg <= STAT_DEGEN;
                    end else if (inv_reg) begin
                        ms_reg <= STAT_INVALID;
                    end else if (sat_reg) begin
                        ms_reg <= STAT_SAT;
                    end else begin
                        ms_reg <= STAT_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/isn_checker.sv]
`default_nettype none
`include "implicit_surface_normal_top_assert.svh"
module isn_checker
    import isn_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_normal_x,
    input wire logic signed [31:0] m_normal_y,
    input wire logic signed [31:0] m_normal_z,
    input wire logic [1:0]         m_status
);

    `ISN_ASSERT_NOW(a_invalid_zero, m_valid && m_status == STAT_INVALID, m_normal_x == 32'sd0 && m_normal_y == 32'sd0 && m_normal_z == 32'sd0)
    `ISN_ASSERT_NOW(a_degen_zero, m_valid && m_status == STAT_DEGEN, m_normal_x == 32'sd0 && m_normal_y == 32'sd0 && m_normal_z == 32'sd0)
    `ISN_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `ISN_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_normal_x) && $stable(m_status))

endmodule

bind implicit_surface_normal_top isn_checker u_isn_checker (.*);
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
    import isn_pkg::*;

    localparam int FB = 16;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        status_t            st;
    } normal_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_data = 2'd0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_func = 1'b0;
    logic [3:0]         s_coef_index = 4'd0;
    logic signed [31:0] s_coef_value = 32'sd0;
    logic signed [31:0] s_point_x = 32'sd0;
    logic signed [31:0] s_point_y = 32'sd0;
    logic signed [31:0] s_point_z = 32'sd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_normal_x;
    logic signed [31:0] m_normal_y;
    logic signed [31:0] m_normal_z;
    logic [1:0]         m_status;

    logic signed [31:0] coef_shadow [16];
    kind_t              kind_shadow = KIND_PLANE;
    normal_t            normals_due [$];
    int unsigned        n_taken = 0;
    int unsigned        n_cfg = 0;
    int unsigned        n_err = 0;
    bit                 quiet = 1'b0;

    always #5 aclk = ~aclk;

    implicit_surface_normal_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_coef_index(s_coef_index),
        .s_coef_value(s_coef_value),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_point_z   (s_point_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_normal_x  (m_normal_x),
        .m_normal_y  (m_normal_y),
        .m_normal_z  (m_normal_z),
        .m_status    (m_status)
    );

    function automatic logic signed [31:0] clamp32(input longint v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // floor of the exact product
    function automatic longint qprod(input logic signed [31:0] a, input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FB;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(input logic signed [31:0] v [3],
                                    output logic signed [31:0] o [3]);
        longint unsigned s, len, m;
        longint a, num;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            a = longint'(v[i]);
            m = (a < 0) ? -a : a;
            s += m * m;
        end
        len = root_floor(s);
        for (int i = 0; i < 3; i++) o[i] = 32'sd0;
        if (len == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            num = longint'(v[i]) <<< FB;
            num = num / longint'(len);
            o[i] = num[31:0];
        end
        return 1'b1;
    endfunction

    function automatic normal_t surface_normal(input logic f, input logic [3:0] idx,
                                               input logic signed [31:0] val,
                                               input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] pz);
        normal_t r;
        logic signed [31:0] p [3], n [3], d [3], pl [3], u [3], rv [3];
        longint acc, proj;
        logic signed [31:0] tp;
        bit hit, ok;
        p[0] = px; p[1] = py; p[2] = pz;
        hit = 1'b0;
        r.st = STAT_OK;
        for (int i = 0; i < 3; i++) n[i] = 32'sd0;
        if (!f) begin
            coef_shadow[idx] = val;
        end else begin
            case (kind_shadow)
                KIND_PLANE: begin
                    for (int i = 0; i < 3; i++) n[i] = coef_shadow[i];
                end
                KIND_QUADRIC: begin
                    for (int i = 0; i < 3; i++) begin
                        acc = longint'(coef_shadow[12 + i]);
                        for (int j = 0; j < 3; j++) acc += qprod(coef_shadow[j * 4 + i], p[j]);
                        n[i] = clamp32(acc, hit);
                    end
                end
                KIND_TORUS: begin
                    proj = 0;
                    for (int i = 0; i < 3; i++) begin
                        d[i] = clamp32(longint'(p[i]) - longint'(coef_shadow[i]), hit);
                        proj += qprod(d[i], coef_shadow[3 + i]);
                    end
                    tp = clamp32(proj, hit);
                    for (int i = 0; i < 3; i++)
                        pl[i] = clamp32(longint'(d[i]) - qprod(tp, coef_shadow[3 + i]), hit);
                    ok = unit_vec(pl, u);
                    if (ok) begin
                        for (int i = 0; i < 3; i++)
                            rv[i] = clamp32(longint'(d[i]) - qprod(coef_shadow[6], u[i]), hit);
                        ok = unit_vec(rv, n);
                    end
                    if (!ok) begin
                        for (int i = 0; i < 3; i++) n[i] = 32'sd0;
                        r.st = STAT_DEGEN;
                    end
                end
                default: r.st = STAT_INVALID;
            endcase
            if (r.st == STAT_OK && hit) r.st = STAT_SAT;
        end
        r.nx = n[0];
        r.ny = n[1];
        r.nz = n[2];
        return r;
    endfunction

    always @(posedge aclk) begin
        normal_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (normals_due.size() == 0) begin
                    $error("result transaction with nothing expected");
                    n_err++;
                end else begin
                    e = normals_due.pop_front();
                    if (m_normal_x !== e.nx) begin
                        $error("normal_x: expected %0d, got %0d", e.nx, m_normal_x);
                        n_err++;
                    end
                    if (m_normal_y !== e.ny) begin
                        $error("normal_y: expected %0d, got %0d", e.ny, m_normal_y);
                        n_err++;
                    end
                    if (m_normal_z !== e.nz) begin
                        $error("normal_z: expected %0d, got %0d", e.nz, m_normal_z);
                        n_err++;
                    end
                    if (m_status !== e.st) begin
                        $error("status: expected %0d, got %0d", e.st, m_status);
                        n_err++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                normals_due.push_back(surface_normal(s_func, s_coef_index, s_coef_value,
                                                     s_point_x, s_point_y, s_point_z));
                n_taken <= n_taken + 1;
            end
            if (cfg_valid && cfg_ready) begin
                kind_shadow = kind_t'(cfg_data);
                n_cfg <= n_cfg + 1;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready = quiet ? 1'b1 : ($urandom_range(99) >= 28);
    end

    task automatic send_item(input logic f, input logic [3:0] idx,
                             input logic signed [31:0] val, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic signed [31:0] pz);
        int unsigned seen;
        if (!quiet && $urandom_range(99) < 28) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_func = f;
        s_coef_index = idx;
        s_coef_value = val;
        s_point_x = px;
        s_point_y = py;
        s_point_z = pz;
        s_valid = 1'b1;
        seen = n_taken;
        do @(negedge aclk); while (n_taken == seen);
    endtask

    task automatic load_word(input logic [3:0] idx, input logic signed [31:0] val);
        send_item(1'b0, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic query(input logic signed [31:0] px, input logic signed [31:0] py,
                         input logic signed [31:0] pz);
        send_item(1'b1, 4'($urandom), $urandom, px, py, pz);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (normals_due.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_kind(input kind_t k);
        int unsigned seen;
        drain();
        cfg_data = k;
        cfg_valid = 1'b1;
        seen = n_cfg;
        do @(negedge aclk); while (n_cfg == seen);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [31:0] pick_q();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        endcase
    endfunction

    task automatic test_load_all();
        for (int i = 0; i < 16; i++)
            load_word(4'(i),
                      (i % 3 == 0) ? 32'sh7FFF_FFFF : (i % 3 == 1) ? 32'sh8000_0000 : 32'sd0);
    endtask

    task automatic test_plane();
        set_kind(KIND_PLANE);
        query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
        load_word(4'd0, 32'sh0001_0000);
        load_word(4'd1, -32'sh0002_8000);
        query(32'sd0, 32'sd0, 32'sd0);
    endtask

    task automatic test_quadric();
        set_kind(KIND_QUADRIC);
        query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        query(32'sd0, 32'sd0, 32'sd0);
        query(32'sh0001_0000, -32'sh0003_0000, 32'sh0000_8000);
    endtask

    task automatic test_torus();
        set_kind(KIND_TORUS);
        for (int i = 0; i < 16; i++) load_word(4'(i), 32'sd0);
        load_word(4'd5, 32'sh0001_0000);
        load_word(4'd6, 32'sh0001_0000);
        query(32'sd0, 32'sd0, 32'sd0);
        query(32'sh0001_0000, 32'sd0, 32'sd0);
        query(32'sh0003_0000, 32'sh0001_0000, 32'sh0000_4000);
        query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    endtask

    task automatic test_invalid();
        set_kind(KIND_INVALID);
        query(32'sh1234_5678, -32'sh0000_0001, 32'sd7);
    endtask

    task automatic test_random(input kind_t k, input int n);
        set_kind(k);
        repeat (n) begin
            if ($urandom_range(99) < 15) load_word(4'($urandom), pick_q());
            else query(pick_q(), pick_q(), pick_q());
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        test_load_all();
        test_plane();
        test_quadric();
        test_torus();
        test_invalid();
        test_random(KIND_PLANE, 100);
        test_random(KIND_QUADRIC, 200);
        test_random(KIND_TORUS, 200);
        test_random(KIND_INVALID, 60);
        quiet = 1'b1;
        test_random(KIND_QUADRIC, 120);
        quiet = 1'b0;
        test_random(KIND_TORUS, 100);
        test_random(KIND_PLANE, 90);
        drain();
        if (n_err == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
